// ----- sv/sslpc_pkg.sv -----
// Shared types, codes and constants for the slew-limited servo pulse controller.
`default_nettype none

package sslpc_pkg;

    // Field widths
    localparam int OP_W     = 3;
    localparam int ANGLE_W  = 21;
    localparam int RATE_W   = 21;
    localparam int POS_W    = 32;
    localparam int STEP_W   = 16;
    localparam int PULSE_W  = 12;
    localparam int CLAMP_W  = 15;
    localparam int SPAN_W   = PULSE_W + 1;
    localparam int NUM_W    = 27;
    localparam int PROD_W   = 28;
    localparam int CFG_IDX_W = 1;

    localparam int NUM_SERVOS = 2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_TICK = 3'd0;
    localparam logic [OP_W-1:0] OP_SET  = 3'd1;
    localparam logic [OP_W-1:0] OP_MOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP = 3'd3;
    localparam logic [OP_W-1:0] OP_IDLE = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 1'd1;

    // Motion constants (centidegrees)
    localparam int FRAMES_PER_SEC = 50;
    localparam int FULL_SCALE     = 18000;
    localparam int IDLE_RATE      = 9000;
    localparam logic [RATE_W-1:0] RATE_MAX = 21'd1048575;
    localparam logic [STEP_W-1:0] IDLE_STEP = STEP_W'(IDLE_RATE / FRAMES_PER_SEC);
    localparam logic [CLAMP_W-1:0] CLAMP_MAX = CLAMP_W'(FULL_SCALE);

    // Divide by 50 as multiply by ceil(2^27/50), exact below 2^21
    localparam int DIV50_MUL_W = 22;
    localparam logic [DIV50_MUL_W-1:0] DIV50_MUL = 22'd2684355;
    localparam int DIV50_SHIFT = 27;

    // Divide by 18000 as multiply by ceil(2^40/18000), exact up to 4095*18000
    localparam int RECIP_W = 26;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 26'd61083980;
    localparam int RECIP_SHIFT = 40;

    // Config reset values
    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 12'd1000;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 12'd2000;
    localparam logic [NUM_W-1:0] MIN_SCALED_RST = NUM_W'(1000 * FULL_SCALE);

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic                      servo_id;
        logic signed [ANGLE_W-1:0] goal_angle;
        logic signed [RATE_W-1:0]  rate;
    } item_t;

    typedef struct packed {
        logic                    servo;
        logic signed [POS_W-1:0] angle;
        logic [CLAMP_W-1:0]      clamp;
        logic                    arrived;
    } tick_rec_t;

    typedef struct packed {
        logic                    servo;
        logic signed [POS_W-1:0] angle;
        logic [PULSE_W-1:0]      pulse;
        logic                    arrived;
    } res_t;

    typedef struct packed {
        logic b_load;
        logic c_load;
        logic o_load;
    } pipe_ctrl_t;

    function automatic logic id_ok(input logic id);
        return int'(id) < NUM_SERVOS;
    endfunction

    function automatic logic is_frame(input item_t it);
        return (it.op == OP_TICK) && id_ok(it.servo_id);
    endfunction

endpackage

`default_nettype wire

// ----- sv/sslpc_motion.sv -----
// Per-servo motion state and the command and frame update, computed combinationally from the input register.
`default_nettype none

module sslpc_motion (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire sslpc_pkg::item_t     item,
    output sslpc_pkg::tick_rec_t      rec
);

    logic signed [sslpc_pkg::POS_W-1:0]   position_reg [sslpc_pkg::NUM_SERVOS];
    logic signed [sslpc_pkg::ANGLE_W-1:0] goal_reg     [sslpc_pkg::NUM_SERVOS];
    logic signed [sslpc_pkg::STEP_W-1:0]  step_reg     [sslpc_pkg::NUM_SERVOS];
    logic                                 seeking_reg  [sslpc_pkg::NUM_SERVOS];

    logic signed [sslpc_pkg::POS_W-1:0]   pos_cur;
    logic signed [sslpc_pkg::ANGLE_W-1:0] goal_cur;
    logic signed [sslpc_pkg::STEP_W-1:0]  step_cur;
    logic                                 seek_cur;
    logic                                 cmd_ok;

    // command path: speed divided by frame rate
    logic signed [sslpc_pkg::RATE_W:0]    rate_ext;
    logic [sslpc_pkg::RATE_W-1:0]         rate_mag;
    logic [sslpc_pkg::RATE_W-1:0]         div_in;
    logic [sslpc_pkg::RATE_W+sslpc_pkg::DIV50_MUL_W-1:0] div_prod;
    logic [sslpc_pkg::STEP_W-2:0]         div_q;
    logic signed [sslpc_pkg::STEP_W-1:0]  move_step;
    logic signed [sslpc_pkg::STEP_W-1:0]  set_step;

    // frame path
    logic signed [sslpc_pkg::POS_W:0]     pos_x;
    logic signed [sslpc_pkg::POS_W:0]     goal_x;
    logic signed [sslpc_pkg::POS_W:0]     step_x;
    logic signed [sslpc_pkg::POS_W:0]     diff;
    logic signed [sslpc_pkg::POS_W:0]     delta;
    logic signed [sslpc_pkg::POS_W:0]     sum;
    logic signed [sslpc_pkg::POS_W-1:0]   sum_sat;
    logic                                 toward_up;
    logic                                 near;
    logic                                 snap;
    logic signed [sslpc_pkg::POS_W-1:0]   pos_next;
    logic signed [sslpc_pkg::STEP_W-1:0]  step_next;
    logic                                 seek_next;

    assign pos_cur  = position_reg[item.servo_id];
    assign goal_cur = goal_reg[item.servo_id];
    assign step_cur = step_reg[item.servo_id];
    assign seek_cur = seeking_reg[item.servo_id];
    assign cmd_ok   = fire && sslpc_pkg::id_ok(item.servo_id);

    always_comb
    begin
        rate_ext = {item.rate[sslpc_pkg::RATE_W-1], item.rate};
        rate_mag = item.rate[sslpc_pkg::RATE_W-1] ? sslpc_pkg::RATE_W'(-rate_ext)
                                                  : sslpc_pkg::RATE_W'(rate_ext);
        if ((item.op == sslpc_pkg::OP_MOVE) && (rate_mag > sslpc_pkg::RATE_MAX))
        begin
            div_in = sslpc_pkg::RATE_MAX;
        end
        else
        begin
            div_in = rate_mag;
        end
        div_prod  = div_in * sslpc_pkg::DIV50_MUL;
        div_q     = div_prod[sslpc_pkg::DIV50_SHIFT +: sslpc_pkg::STEP_W-1];
        move_step = $signed({1'b0, div_q});
        set_step  = item.rate[sslpc_pkg::RATE_W-1] ? -move_step : move_step;
    end

    always_comb
    begin
        pos_x  = {pos_cur[sslpc_pkg::POS_W-1], pos_cur};
        goal_x = {{(sslpc_pkg::POS_W+1-sslpc_pkg::ANGLE_W){goal_cur[sslpc_pkg::ANGLE_W-1]}},
                  goal_cur};
        step_x = {{(sslpc_pkg::POS_W+1-sslpc_pkg::STEP_W){step_cur[sslpc_pkg::STEP_W-1]}},
                  step_cur};
        diff      = goal_x - pos_x;
        toward_up = !diff[sslpc_pkg::POS_W] && (diff != '0);
        near      = toward_up ? (diff <= step_x) : (diff >= -step_x);
        snap      = seek_cur && near;

        // seeking moves toward the goal; velocity mode drifts by the signed step
        delta = (seek_cur && !toward_up) ? -step_x : step_x;
        sum   = pos_x + delta;
        if (sum[sslpc_pkg::POS_W] != sum[sslpc_pkg::POS_W-1])
        begin
            sum_sat = sum[sslpc_pkg::POS_W] ? {1'b1, {(sslpc_pkg::POS_W-1){1'b0}}}
                                            : {1'b0, {(sslpc_pkg::POS_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum[sslpc_pkg::POS_W-1:0];
        end

        pos_next  = snap ? goal_x[sslpc_pkg::POS_W-1:0] : sum_sat;
        step_next = snap ? '0 : step_cur;
        seek_next = seek_cur && !near;

        rec.servo   = item.servo_id;
        rec.angle   = pos_next;
        rec.arrived = !seek_next;
        if (pos_next[sslpc_pkg::POS_W-1])
        begin
            rec.clamp = '0;
        end
        else if (pos_next > $signed(sslpc_pkg::POS_W'(sslpc_pkg::FULL_SCALE)))
        begin
            rec.clamp = sslpc_pkg::CLAMP_MAX;
        end
        else
        begin
            rec.clamp = pos_next[sslpc_pkg::CLAMP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sslpc_pkg::NUM_SERVOS; i++)
            begin
                position_reg[i] <= '0;
                goal_reg[i]     <= '0;
                step_reg[i]     <= '0;
                seeking_reg[i]  <= 1'b0;
            end
        end
        else if (cmd_ok)
        begin
            unique case (item.op)
                sslpc_pkg::OP_TICK:
                begin
                    position_reg[item.servo_id] <= pos_next;
                    step_reg[item.servo_id]     <= step_next;
                    seeking_reg[item.servo_id]  <= seek_next;
                end
                sslpc_pkg::OP_SET:
                begin
                    step_reg[item.servo_id]    <= set_step;
                    seeking_reg[item.servo_id] <= 1'b0;
                end
                sslpc_pkg::OP_MOVE:
                begin
                    goal_reg[item.servo_id]    <= item.goal_angle;
                    step_reg[item.servo_id]    <= move_step;
                    seeking_reg[item.servo_id] <= 1'b1;
                end
                sslpc_pkg::OP_STOP:
                begin
                    step_reg[item.servo_id]    <= '0;
                    seeking_reg[item.servo_id] <= 1'b0;
                end
                sslpc_pkg::OP_IDLE:
                begin
                    goal_reg[item.servo_id]    <= '0;
                    step_reg[item.servo_id]    <= sslpc_pkg::IDLE_STEP;
                    seeking_reg[item.servo_id] <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

`ifndef SYNTH
    // a seeking servo never carries a negative step
    a_seek_step_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        seeking_reg[item.servo_id] |-> !step_reg[item.servo_id][sslpc_pkg::STEP_W-1])
        else $error("seeking servo holds a negative step");

    // arrival zeroes the speed and ends the seek
    a_snap_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_ok && (item.op == sslpc_pkg::OP_TICK) && snap)
        |=> (step_reg[$past(item.servo_id)] == '0) && !seeking_reg[$past(item.servo_id)])
        else $error("arrival did not clear speed and seek");
`endif

endmodule

`default_nettype wire

// ----- sv/sslpc_pulse.sv -----
// Pulse-width pipeline: scale the clamped angle over the pulse span, then divide.
`default_nettype none

module sslpc_pulse (
    input  wire logic                              clk,
    input  wire sslpc_pkg::pipe_ctrl_t             ctrl,
    input  wire sslpc_pkg::tick_rec_t              rec,
    input  wire logic [sslpc_pkg::NUM_W-1:0]       min_scaled,
    input  wire logic signed [sslpc_pkg::SPAN_W-1:0] span,
    output sslpc_pkg::res_t                        res
);

    sslpc_pkg::tick_rec_t                   b_rec_reg;
    logic signed [sslpc_pkg::PROD_W-1:0]    prod;
    logic signed [sslpc_pkg::PROD_W:0]      num_sum;
    logic [sslpc_pkg::NUM_W-1:0]            c_num_next;
    logic [sslpc_pkg::NUM_W-1:0]            c_num_reg;
    logic                                   c_servo_reg;
    logic signed [sslpc_pkg::POS_W-1:0]     c_angle_reg;
    logic                                   c_arrived_reg;
    logic [sslpc_pkg::NUM_W+sslpc_pkg::RECIP_W-1:0] q_prod;
    sslpc_pkg::res_t                        o_next;
    sslpc_pkg::res_t                        o_reg;

    // min*18000 + c*(max-min): never negative, below 2^27
    always_comb
    begin
        prod       = $signed({1'b0, b_rec_reg.clamp}) * span;
        num_sum    = $signed({2'b00, min_scaled}) + {prod[sslpc_pkg::PROD_W-1], prod};
        c_num_next = num_sum[sslpc_pkg::NUM_W-1:0];
    end

    // floor divide by full scale through the reciprocal
    always_comb
    begin
        q_prod         = c_num_reg * sslpc_pkg::RECIP_MUL;
        o_next.servo   = c_servo_reg;
        o_next.angle   = c_angle_reg;
        o_next.pulse   = q_prod[sslpc_pkg::RECIP_SHIFT +: sslpc_pkg::PULSE_W];
        o_next.arrived = c_arrived_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.b_load)
        begin
            b_rec_reg <= rec;
        end
        if (ctrl.c_load)
        begin
            c_num_reg     <= c_num_next;
            c_servo_reg   <= b_rec_reg.servo;
            c_angle_reg   <= b_rec_reg.angle;
            c_arrived_reg <= b_rec_reg.arrived;
        end
        if (ctrl.o_load)
        begin
            o_reg <= o_next;
        end
    end

    assign res = o_reg;

endmodule

`default_nettype wire

// ----- sv/servo_slew_limited_pulse_controller.sv -----
// Top level of the slew-limited RC servo pulse controller for two servos.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in      | to block  | in_valid / in_ready  | op, servo_id, goal_angle, rate
//   out     | from block| out_valid / out_ready| out_servo, out_angle, pulse_us, arrived
//   cfg     | to block  | cfg_we               | cfg_index, cfg_wdata
//
// One item per cycle sustained while the output is ready. A transfer lands in the
// input register; on retiring it updates the servo state in one pass and, for a
// frame tick, starts the pulse pipeline (multiply by span, then reciprocal
// multiply) through stages B, C and O. Commands give no result and retire without
// waiting on the pipe. Reset clears all servo state and loads the default pulse
// limits. A stalled output holds its result while the stages behind it keep
// filling; each stage holds only once the stage ahead of it is full.
`default_nettype none

module servo_slew_limited_pulse_controller (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [sslpc_pkg::OP_W-1:0]           op,
    input  wire logic                                 servo_id,
    input  wire logic signed [sslpc_pkg::ANGLE_W-1:0] goal_angle,
    input  wire logic signed [sslpc_pkg::RATE_W-1:0]  rate,

    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      out_servo,
    output logic signed [sslpc_pkg::POS_W-1:0]        out_angle,
    output logic [sslpc_pkg::PULSE_W-1:0]             pulse_us,
    output logic                                      arrived,

    input  wire logic                                 cfg_we,
    input  wire logic [sslpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sslpc_pkg::PULSE_W-1:0]        cfg_wdata
);

    // pulse limits; min*18000 is kept alongside so the scaling stage needs one multiply
    logic [sslpc_pkg::PULSE_W-1:0]        min_pulse_reg;
    logic [sslpc_pkg::PULSE_W-1:0]        max_pulse_reg;
    logic [sslpc_pkg::NUM_W-1:0]          min_scaled_reg;
    logic signed [sslpc_pkg::SPAN_W-1:0]  span;

    // stage valids: A input register, B tick record, C scaled sum, O output
    logic                  a_valid_reg;
    sslpc_pkg::item_t      a_item_reg;
    logic                  b_valid_reg;
    logic                  c_valid_reg;
    logic                  o_valid_reg;

    logic                  a_has_result;
    logic                  a_take;
    logic                  b_ready;
    logic                  c_ready;
    logic                  o_ready;

    sslpc_pkg::item_t      in_item;
    sslpc_pkg::tick_rec_t  rec;
    sslpc_pkg::pipe_ctrl_t ctrl;
    sslpc_pkg::res_t       res;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg  <= sslpc_pkg::MIN_PULSE_RST;
            max_pulse_reg  <= sslpc_pkg::MAX_PULSE_RST;
            min_scaled_reg <= sslpc_pkg::MIN_SCALED_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sslpc_pkg::CFG_MIN_PULSE:
                begin
                    min_pulse_reg  <= cfg_wdata;
                    min_scaled_reg <= sslpc_pkg::NUM_W'(cfg_wdata)
                                      * sslpc_pkg::NUM_W'(sslpc_pkg::FULL_SCALE);
                end
                sslpc_pkg::CFG_MAX_PULSE:
                begin
                    max_pulse_reg <= cfg_wdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign span = $signed({1'b0, max_pulse_reg}) - $signed({1'b0, min_pulse_reg});

    // ready chain from the output back to the input register
    always_comb
    begin
        o_ready      = !o_valid_reg || out_ready;
        c_ready      = !c_valid_reg || o_ready;
        b_ready      = !b_valid_reg || c_ready;
        a_has_result = sslpc_pkg::is_frame(a_item_reg);
        // a command retires at once; a tick waits for room in stage B
        a_take       = a_valid_reg && (!a_has_result || b_ready);
        in_ready     = !a_valid_reg || a_take;

        ctrl.b_load  = a_take && a_has_result;
        ctrl.c_load  = c_ready && b_valid_reg;
        ctrl.o_load  = o_ready && c_valid_reg;

        in_item.op         = op;
        in_item.servo_id   = servo_id;
        in_item.goal_angle = goal_angle;
        in_item.rate       = rate;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_take && a_has_result;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= c_valid_reg;
            end
        end
    end

    // hold the input payload until it retires
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_item_reg <= in_item;
        end
    end

    sslpc_motion u_motion (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (a_take),
        .item  (a_item_reg),
        .rec   (rec)
    );

    sslpc_pulse u_pulse (
        .clk        (clk),
        .ctrl       (ctrl),
        .rec        (rec),
        .min_scaled (min_scaled_reg),
        .span       (span),
        .res        (res)
    );

    assign out_valid = o_valid_reg;
    assign out_servo = res.servo;
    assign out_angle = res.angle;
    assign pulse_us  = res.pulse;
    assign arrived   = res.arrived;

`ifndef SYNTH
    // a result enters stage B only from a tick that retired from stage A
    a_b_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(b_valid_reg) |-> $past(a_valid_reg && a_has_result))
        else $error("stage B filled without a retired tick");

    // a tick blocked by a full pipe stays put in the input register
    a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !in_ready) |=> (a_valid_reg && $stable(a_item_reg)))
        else $error("input register lost a pending item");

    // a command never blocks the input
    a_cmd_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !a_has_result) |-> in_ready)
        else $error("command stalled the input");
`endif

endmodule

`default_nettype wire

// ----- verif/servo_frame_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the servo pulse controller: tracks servo state, predicts frame reports, compares.
module servo_frame_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [sslpc_pkg::OP_W-1:0]           op,
    input  logic                                 servo_id,
    input  logic signed [sslpc_pkg::ANGLE_W-1:0] goal_angle,
    input  logic signed [sslpc_pkg::RATE_W-1:0]  rate,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic                                 out_servo,
    input  logic signed [sslpc_pkg::POS_W-1:0]   out_angle,
    input  logic [sslpc_pkg::PULSE_W-1:0]        pulse_us,
    input  logic                                 arrived,
    input  logic                                 cfg_we,
    input  logic [sslpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sslpc_pkg::PULSE_W-1:0]        cfg_wdata,
    output int                                   mismatches,
    output int                                   outstanding
);
    import sslpc_pkg::*;

    localparam longint POS_HI      = 64'sd2147483647;
    localparam longint POS_LO      = -64'sd2147483648;

    logic signed [POS_W-1:0]   servo_pos     [NUM_SERVOS];
    logic signed [ANGLE_W-1:0] servo_goal    [NUM_SERVOS];
    logic signed [RATE_W-1:0]  servo_vel     [NUM_SERVOS];
    logic                      servo_seeking [NUM_SERVOS];
    logic [PULSE_W-1:0]        lo_limit;
    logic [PULSE_W-1:0]        hi_limit;

    res_t reports_due[$];
    int   fail_count = 0;
    int   due_count  = 0;

    assign mismatches  = fail_count;
    assign outstanding = due_count;

    function automatic logic signed [POS_W-1:0] clip_angle(input longint v);
        if (v > POS_HI)
            return POS_W'(POS_HI);
        if (v < POS_LO)
            return POS_W'(POS_LO);
        return POS_W'(v);
    endfunction

    // Pulse scales linearly over 0..180 degrees, floor of the exact quotient.
    function automatic logic [PULSE_W-1:0] pulse_for(input logic signed [POS_W-1:0] angle,
                                                     input logic [PULSE_W-1:0] lo,
                                                     input logic [PULSE_W-1:0] hi);
        longint clamped;
        longint span;
        longint scaled;
        clamped = angle;
        if (clamped < 0)
            clamped = 0;
        else if (clamped > FULL_SCALE)
            clamped = FULL_SCALE;
        span   = longint'(hi) - longint'(lo);
        scaled = longint'(lo) * FULL_SCALE + clamped * span;
        return PULSE_W'(scaled / FULL_SCALE);
    endfunction

    // One 20 ms frame of motion for a servo.
    task automatic advance_frame(input int id);
        longint step;
        longint offset;
        longint offset_mag;
        step = longint'(servo_vel[id]) / FRAMES_PER_SEC;
        if (servo_seeking[id])
        begin
            offset     = longint'(servo_goal[id]) - longint'(servo_pos[id]);
            offset_mag = (offset < 0) ? -offset : offset;
            if (offset_mag <= step)
            begin
                servo_pos[id]     = servo_goal[id];
                servo_seeking[id] = 1'b0;
                servo_vel[id]     = '0;
            end
            else if (offset > 0)
                servo_pos[id] = clip_angle(longint'(servo_pos[id]) + step);
            else
                servo_pos[id] = clip_angle(longint'(servo_pos[id]) - step);
        end
        else
            servo_pos[id] = clip_angle(longint'(servo_pos[id]) + step);
    endtask

    task automatic report_mismatch(input string name, input longint want_v, input longint got_v);
        fail_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        res_t   want;
        int     sid;
        longint mag;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SERVOS; i++)
            begin
                servo_pos[i]     = '0;
                servo_goal[i]    = '0;
                servo_vel[i]     = '0;
                servo_seeking[i] = 1'b0;
            end
            lo_limit = MIN_PULSE_RST;
            hi_limit = MAX_PULSE_RST;
            reports_due.delete();
            due_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (reports_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: extra report: servo %0d angle %0d pulse %0d arrived %0d",
                             $time, out_servo, out_angle, pulse_us, arrived);
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (out_servo !== want.servo)
                        report_mismatch("servo", longint'(want.servo), longint'(out_servo));
                    if (out_angle !== want.angle)
                        report_mismatch("angle", longint'($signed(want.angle)), longint'(out_angle));
                    if (pulse_us !== want.pulse)
                        report_mismatch("pulse", longint'(want.pulse), longint'(pulse_us));
                    if (arrived !== want.arrived)
                        report_mismatch("arrived", longint'(want.arrived), longint'(arrived));
                end
            end

            if (in_valid && in_ready)
            begin
                sid = int'(servo_id);
                if (sid < NUM_SERVOS)
                begin
                    case (op)
                        OP_TICK:
                        begin
                            advance_frame(sid);
                            want.servo   = servo_id;
                            want.angle   = servo_pos[sid];
                            want.pulse   = pulse_for(servo_pos[sid], lo_limit, hi_limit);
                            want.arrived = !servo_seeking[sid];
                            reports_due.push_back(want);
                        end
                        OP_SET:
                        begin
                            servo_vel[sid]     = rate;
                            servo_seeking[sid] = 1'b0;
                        end
                        OP_MOVE:
                        begin
                            // speed is the magnitude of rate, held to the positive range
                            mag = rate;
                            if (mag < 0)
                                mag = -mag;
                            if (mag > longint'(RATE_MAX))
                                mag = longint'(RATE_MAX);
                            servo_goal[sid]    = goal_angle;
                            servo_vel[sid]     = RATE_W'(mag);
                            servo_seeking[sid] = 1'b1;
                        end
                        OP_STOP:
                        begin
                            servo_vel[sid]     = '0;
                            servo_seeking[sid] = 1'b0;
                        end
                        OP_IDLE:
                        begin
                            servo_goal[sid]    = '0;
                            servo_vel[sid]     = RATE_W'(IDLE_RATE);
                            servo_seeking[sid] = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_PULSE: lo_limit = cfg_wdata;
                    CFG_MAX_PULSE: hi_limit = cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end

            due_count = reports_due.size();
        end
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Top-level testbench: drives commands, frame ticks and pulse limits into the servo controller.
module tb_top;
    import sslpc_pkg::*;

    // Extremes of the 21-bit signed angle and rate fields
    localparam logic signed [ANGLE_W-1:0] ANGLE_HI = {1'b0, {(ANGLE_W-1){1'b1}}};
    localparam logic signed [ANGLE_W-1:0] ANGLE_LO = {1'b1, {(ANGLE_W-1){1'b0}}};
    localparam logic signed [RATE_W-1:0]  RATE_HI  = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic signed [RATE_W-1:0]  RATE_LO  = {1'b1, {(RATE_W-1){1'b0}}};
    localparam logic [PULSE_W-1:0]        PULSE_TOP = {PULSE_W{1'b1}};

    // Opcodes the block must ignore
    localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_IDLE + 1'b1;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = {OP_W{1'b1}};

    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 310;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    // Tick pairs in the back-to-back run at full speed
    localparam int SAT_TICKS    = 12;
    localparam int LIMIT        = 3000000;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      in_valid   = 1'b0;
    logic [OP_W-1:0]           op         = OP_TICK;
    logic                      servo_id   = 1'b0;
    logic signed [ANGLE_W-1:0] goal_angle = '0;
    logic signed [RATE_W-1:0]  rate       = '0;
    logic                      out_ready  = 1'b0;
    logic                      cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index  = CFG_MIN_PULSE;
    logic [PULSE_W-1:0]        cfg_wdata  = '0;

    wire logic                      in_ready;
    wire logic                      out_valid;
    wire logic                      out_servo;
    wire logic signed [POS_W-1:0]   out_angle;
    wire logic [PULSE_W-1:0]        pulse_us;
    wire logic                      arrived;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int burst_left  = 0;

    // Shared between the stimulus and the receiver process
    bit hold_req  = 1'b0;
    bit full_rate = 1'b0;

    servo_slew_limited_pulse_controller dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .servo_id   (servo_id),
        .goal_angle (goal_angle),
        .rate       (rate),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_servo  (out_servo),
        .out_angle  (out_angle),
        .pulse_us   (pulse_us),
        .arrived    (arrived),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    servo_frame_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .servo_id    (servo_id),
        .goal_angle  (goal_angle),
        .rate        (rate),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_servo   (out_servo),
        .out_angle   (out_angle),
        .pulse_us    (pulse_us),
        .arrived     (arrived),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: give up after a generous number of cycles
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OP_W-1:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return OP_SET;
        if (r < 65)
            return OP_MOVE;
        if (r < 82)
            return OP_STOP;
        return OP_IDLE;
    endfunction

    // Goals cluster around the 0..180 degree travel, with full-field values mixed in
    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return ANGLE_W'($urandom_range(0, 23000) - 2500);
        if (r < 75)
            return ANGLE_W'($urandom);
        if (r < 90)
        begin
            case ($urandom_range(0, 3))
                0:       return ANGLE_HI;
                1:       return ANGLE_LO;
                2:       return '0;
                default: return ANGLE_W'(FULL_SCALE);
            endcase
        end
        return ANGLE_W'($urandom_range(0, FULL_SCALE));
    endfunction

    // Moderate speeds take several frames to arrive; tiny ones truncate to no motion
    function automatic logic signed [RATE_W-1:0] pick_rate();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            v = $urandom_range(0, 40000);
            return RATE_W'($urandom_range(0, 1) ? -v : v);
        end
        if (r < 55)
        begin
            v = $urandom_range(0, 300);
            return RATE_W'($urandom_range(0, 1) ? -v : v);
        end
        if (r < 80)
            return RATE_W'($urandom);
        case ($urandom_range(0, 3))
            0:       return RATE_HI;
            1:       return RATE_LO;
            2:       return '0;
            default: return RATE_W'(FRAMES_PER_SEC);
        endcase
    endfunction

    // Offer one item and hold it until the transfer. Valid stays high on exit so a
    // back-to-back item follows without a bubble.
    task automatic send_item(input logic [OP_W-1:0] o, input logic id,
                             input logic signed [ANGLE_W-1:0] g,
                             input logic signed [RATE_W-1:0] r);
        in_valid   <= 1'b1;
        op         <= o;
        servo_id   <= id;
        goal_angle <= g;
        rate       <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid for the given gap and scramble the payload while nothing is offered
    task automatic input_gap(input int n);
        if (n > 0)
        begin
            in_valid   <= 1'b0;
            op         <= OP_W'($urandom);
            servo_id   <= 1'($urandom);
            goal_angle <= ANGLE_W'($urandom);
            rate       <= RATE_W'($urandom);
            repeat (n)
                @(posedge clk);
        end
    endtask

    // Idle between items, except inside a back-to-back burst
    task automatic next_gap();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            input_gap(pick_gap());
            if ($urandom_range(0, 99) < 4)
                burst_left = $urandom_range(20, 80);
        end
    endtask

    // Stop offering, wait for every predicted report, then cover the pipeline
    // latency so no command is still in flight.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Write both pulse limits on consecutive cycles
    task automatic write_limits(input logic [PULSE_W-1:0] lo, input logic [PULSE_W-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MIN_PULSE;
        cfg_wdata <= lo;
        @(posedge clk);
        cfg_index <= CFG_MAX_PULSE;
        cfg_wdata <= hi;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_directed();
        // From rest, then a move whose rate is the most negative value
        send_item(OP_TICK, 1'b0, '0, '0);                  next_gap();
        send_item(OP_MOVE, 1'b0, ANGLE_HI, RATE_LO);       next_gap();
        send_item(OP_TICK, 1'b0, '0, '0);                  next_gap();
        send_item(OP_MOVE, 1'b0, ANGLE_LO, RATE_HI);       next_gap();
        send_item(OP_TICK, 1'b0, '0, '0);                  next_gap();
        send_item(OP_TICK, 1'b0, '0, '0);                  next_gap();
        send_item(OP_STOP, 1'b0, ANGLE_HI, RATE_HI);       next_gap();
        send_item(OP_TICK, 1'b0, '0, '0);                  next_gap();
        // Idle already at zero snaps on the first frame
        send_item(OP_IDLE, 1'b1, ANGLE_HI, RATE_LO);       next_gap();
        send_item(OP_TICK, 1'b1, ANGLE_LO, RATE_LO);       next_gap();
        // Velocity mode at both speed extremes
        send_item(OP_SET, 1'b1, ANGLE_LO, RATE_LO);        next_gap();
        send_item(OP_TICK, 1'b1, '0, '0);                  next_gap();
        send_item(OP_SET, 1'b1, ANGLE_HI, RATE_HI);        next_gap();
        send_item(OP_TICK, 1'b1, '0, '0);                  next_gap();
        // One step lands exactly on 180 degrees
        send_item(OP_MOVE, 1'b1, ANGLE_W'(FULL_SCALE), RATE_W'(900000)); next_gap();
        send_item(OP_TICK, 1'b1, '0, '0);                  next_gap();
        // Speed below one centidegree per frame never moves
        send_item(OP_MOVE, 1'b1, ANGLE_W'(100), RATE_W'(FRAMES_PER_SEC - 1)); next_gap();
        send_item(OP_TICK, 1'b1, '0, '0);                  next_gap();
        // Zero speed onto the current angle arrives at once
        send_item(OP_MOVE, 1'b1, ANGLE_W'(FULL_SCALE), '0); next_gap();
        send_item(OP_TICK, 1'b1, '0, '0);                  next_gap();
        // Idle from a negative angle
        send_item(OP_IDLE, 1'b0, '0, '0);                  next_gap();
        send_item(OP_TICK, 1'b0, '0, '0);                  next_gap();
        // Unused opcodes must leave no trace
        send_item(OP_UNUSED_LO, 1'b0, ANGLE_HI, RATE_HI);  next_gap();
        send_item(OP_UNUSED_LO + 1'b1, 1'b1, ANGLE_LO, RATE_LO); next_gap();
        send_item(OP_UNUSED_HI, 1'b0, ANGLE_LO, RATE_HI);  next_gap();
    endtask

    // Mostly a command followed by a run of ticks, most on the same servo; the rest is
    // noise: unused opcodes and stray ticks.
    task automatic run_random(input int quota);
        int         sent;
        int         run_len;
        logic       id;
        logic [OP_W-1:0] noise_op;
        sent = 0;
        while (sent < quota)
        begin
            id = 1'($urandom);
            if ($urandom_range(0, 99) < 88)
            begin
                send_item(pick_command(), id, pick_angle(), pick_rate());
                sent++;
                next_gap();
                run_len = $urandom_range(1, 10);
                repeat (run_len)
                begin
                    send_item(OP_TICK, ($urandom_range(0, 99) < 85) ? id : !id,
                              ANGLE_W'($urandom), RATE_W'($urandom));
                    sent++;
                    next_gap();
                end
            end
            else if ($urandom_range(0, 1))
            begin
                noise_op = OP_W'($urandom_range(int'(OP_UNUSED_LO), int'(OP_UNUSED_HI)));
                send_item(noise_op, id, ANGLE_W'($urandom), RATE_W'($urandom));
                next_gap();
            end
            else
            begin
                send_item(OP_TICK, id, ANGLE_W'($urandom), RATE_W'($urandom));
                sent++;
                next_gap();
            end
        end
    endtask

    // Run both servos at full speed in opposite directions, back to back with the
    // receiver always ready, then steer both back.
    task automatic run_saturation();
        full_rate = 1'b1;
        send_item(OP_SET, 1'b0, '0, RATE_HI);
        send_item(OP_SET, 1'b1, '0, RATE_LO);
        repeat (SAT_TICKS)
        begin
            send_item(OP_TICK, 1'b0, '0, '0);
            send_item(OP_TICK, 1'b1, '0, '0);
        end
        send_item(OP_MOVE, 1'b0, '0, RATE_HI);
        send_item(OP_MOVE, 1'b1, ANGLE_HI, RATE_HI);
        repeat (4)
        begin
            send_item(OP_TICK, 1'b0, '0, '0);
            send_item(OP_TICK, 1'b1, '0, '0);
        end
        full_rate = 1'b0;
    endtask

    // Receiver: ready with random stalls and ready runs. A hold-off request
    // stalls it for a long stretch so the pipeline backs up into the input.
    initial
    begin : receiver
        int stall_left;
        int hold_left;
        int run_left;
        stall_left = 0;
        hold_left  = 0;
        run_left   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (full_rate || run_left > 0)
            begin
                out_ready <= 1'b1;
                if (run_left > 0)
                    run_left--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
                else if ($urandom_range(0, 99) < 3)
                    run_left = $urandom_range(50, 200);
            end
        end
    end

    initial
    begin : stimulus
        logic [PULSE_W-1:0] lo;
        logic [PULSE_W-1:0] hi;
        // Hold reset at the start, then release it once
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_limits(MIN_PULSE_RST, MAX_PULSE_RST);
        run_directed();

        // Sweep the pulse limits: full span, reversed, both ends equal, random
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    lo = '0;
                    hi = PULSE_TOP;
                end
                1:
                begin
                    lo = PULSE_TOP;
                    hi = '0;
                end
                2:
                begin
                    lo = '0;
                    hi = '0;
                end
                3:
                begin
                    lo = PULSE_TOP;
                    hi = PULSE_TOP;
                end
                default:
                begin
                    lo = PULSE_W'($urandom);
                    hi = PULSE_W'($urandom);
                end
            endcase
            settle();
            write_limits(lo, hi);
            if (ph == 1)
            begin
                // Stall the output mid-phase while items keep coming
                run_random(PHASE_ITEMS / 2);
                hold_req = 1'b1;
                run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            end
            else
                run_random(PHASE_ITEMS);
        end

        settle();
        write_limits(PULSE_W'($urandom), PULSE_W'($urandom));
        run_saturation();
        settle();

        if (mismatches == 0 && outstanding == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
